[hw/rtl/dtq_pkg.sv]
package dtq_pkg;

  localparam int KindW  = 3;
  localparam int IdPortW = 5;
  localparam int NowW   = 48;
  localparam int DurW   = 32;
  localparam int ModeW  = 2;
  localparam int NdW    = 49;

  typedef enum logic [KindW-1:0] {
    KindStartOneshot  = 3'd0,
    KindStartTimeout  = 3'd1,
    KindStartPeriodic = 3'd2,
    KindStop          = 3'd3,
    KindPoll          = 3'd4,
    KindClear         = 3'd5
  } kind_e;

  localparam logic [ModeW-1:0] ModePeriodic = 2'd2;

  typedef struct packed {
    logic clear_all;
    logic deactivate;
    logic load_all;
    logic load_deadline;
  } wr_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StFire = 4'b0100,
    StDone = 4'b1000
  } state_e;

endpackage

[hw/rtl/dtq_cell.sv]
module dtq_cell #(
  parameter int CELL_ID   = 0,
  parameter int IDW       = 5,
  parameter int TIME_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtq_pkg::wr_t                wr_i,
  input  logic [IDW-1:0]              wr_id_i,
  input  logic [TIME_BITS-1:0]        wr_deadline_i,
  input  logic [dtq_pkg::DurW-1:0]    wr_period_i,
  input  logic [dtq_pkg::ModeW-1:0]   wr_mode_i,
  input  logic                        in_valid_i,
  input  logic [TIME_BITS-1:0]        in_deadline_i,
  input  logic [dtq_pkg::DurW-1:0]    in_period_i,
  input  logic [dtq_pkg::ModeW-1:0]   in_mode_i,
  input  logic [IDW-1:0]              in_id_i,
  output logic                        out_valid_o,
  output logic [TIME_BITS-1:0]        out_deadline_o,
  output logic [dtq_pkg::DurW-1:0]    out_period_o,
  output logic [dtq_pkg::ModeW-1:0]   out_mode_o,
  output logic [IDW-1:0]              out_id_o
);

  localparam logic [IDW-1:0] MyId = IDW'(CELL_ID);

  logic                      active_q;
  logic [TIME_BITS-1:0]      deadline_q;
  logic [dtq_pkg::DurW-1:0]  period_q;
  logic [dtq_pkg::ModeW-1:0] mode_q;
  logic                      sel;
  logic                      take_own;

  logic                      best_valid_q;
  logic [TIME_BITS-1:0]      best_deadline_q;
  logic [dtq_pkg::DurW-1:0]  best_period_q;
  logic [dtq_pkg::ModeW-1:0] best_mode_q;
  logic [IDW-1:0]            best_id_q;

  assign sel      = (wr_id_i == MyId);
  assign take_own = active_q && (!in_valid_i || (deadline_q < in_deadline_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (wr_i.clear_all) begin
      active_q <= 1'b0;
    end else if (sel && wr_i.deactivate) begin
      active_q <= 1'b0;
    end else if (sel && wr_i.load_all) begin
      active_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && (wr_i.load_all || wr_i.load_deadline) && !wr_i.clear_all) begin
      deadline_q <= wr_deadline_i;
    end
    if (sel && wr_i.load_all && !wr_i.clear_all) begin
      period_q <= wr_period_i;
      mode_q   <= wr_mode_i;
    end
  end

  // advance the running minimum one cell down the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
    end else begin
      best_valid_q <= take_own || in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_own) begin
      best_deadline_q <= deadline_q;
      best_period_q   <= period_q;
      best_mode_q     <= mode_q;
      best_id_q       <= MyId;
    end else begin
      best_deadline_q <= in_deadline_i;
      best_period_q   <= in_period_i;
      best_mode_q     <= in_mode_i;
      best_id_q       <= in_id_i;
    end
  end

  assign out_valid_o    = best_valid_q;
  assign out_deadline_o = best_deadline_q;
  assign out_period_o   = best_period_q;
  assign out_mode_o     = best_mode_q;
  assign out_id_o       = best_id_q;

endmodule

[hw/rtl/deadline_timer_queue.sv]
// Timer queue of NUM_SLOTS slots, one cell per slot, each holding an active mark, a
// deadline, a period and a mode. After every command a search token walks the row of
// cells one cell per cycle and comes out of the last cell with the earliest active
// deadline (lowest id on ties). Start, stop, clear and unused kinds walk the row once and
// then present their result; a poll walks the row twice, once to pick the slot to fire and
// once for the status, and then presents its result. One command is in flight at a time;
// the result sits in an output register, so the next command is taken while the previous
// result still waits. Deadlines saturate at 2^TIME_BITS - 1.
module deadline_timer_queue #(
  parameter int NUM_SLOTS = 32,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dtq_pkg::KindW-1:0]         kind_i,
  input  logic [dtq_pkg::IdPortW-1:0]       timer_id_i,
  input  logic [dtq_pkg::NowW-1:0]          now_i,
  input  logic [dtq_pkg::DurW-1:0]          duration_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              fired_o,
  output logic [dtq_pkg::IdPortW-1:0]       fired_id_o,
  output logic [dtq_pkg::ModeW-1:0]         fired_mode_o,
  output logic signed [dtq_pkg::NdW-1:0]    next_deadline_o,
  output logic                              queue_empty_o
);

  localparam int IDW = $clog2(NUM_SLOTS);
  localparam int CW  = (TIME_BITS > dtq_pkg::NowW) ? TIME_BITS : dtq_pkg::NowW;
  localparam int NW  = (TIME_BITS > dtq_pkg::NdW) ? TIME_BITS : dtq_pkg::NdW;
  localparam logic [IDW-1:0] LastCnt = IDW'(NUM_SLOTS - 1);

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [dtq_pkg::DurW-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + (TIME_BITS+1)'(b);
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  dtq_pkg::state_e state_q, state_d;
  logic [IDW-1:0]  cnt_q, cnt_d;
  logic            poll_q, poll_d;
  logic            scanned_q, scanned_d;
  logic [TIME_BITS-1:0] now_q;

  logic                      fired_q, fired_d;
  logic [IDW-1:0]            fired_id_q, fired_id_d;
  logic [dtq_pkg::ModeW-1:0] fired_mode_q, fired_mode_d;

  logic                      out_valid_q;
  logic                      o_fired_q;
  logic [dtq_pkg::IdPortW-1:0] o_fired_id_q;
  logic [dtq_pkg::ModeW-1:0] o_fired_mode_q;
  logic [dtq_pkg::NdW-1:0]   o_nd_q;
  logic                      o_empty_q;

  logic [CW-1:0]             now_w;
  logic [CW-1:0]             tmax_w;
  logic [TIME_BITS-1:0]      now_c;
  logic                      accept;
  logic                      id_ok;
  logic                      fire_now;
  logic                      out_load;
  logic [NW-1:0]             nd_w;

  dtq_pkg::wr_t              wr;
  logic [IDW-1:0]            wr_id;
  logic [TIME_BITS-1:0]      wr_deadline;
  logic [dtq_pkg::ModeW-1:0] wr_mode;

  logic                      ch_valid    [NUM_SLOTS+1];
  logic [TIME_BITS-1:0]      ch_deadline [NUM_SLOTS+1];
  logic [dtq_pkg::DurW-1:0]  ch_period   [NUM_SLOTS+1];
  logic [dtq_pkg::ModeW-1:0] ch_mode     [NUM_SLOTS+1];
  logic [IDW-1:0]            ch_id       [NUM_SLOTS+1];

  assign in_ready_o = (state_q == dtq_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign now_w  = CW'(now_i);
  assign tmax_w = CW'({TIME_BITS{1'b1}});
  assign now_c  = (now_w > tmax_w) ? {TIME_BITS{1'b1}} : now_w[TIME_BITS-1:0];
  assign id_ok  = (32'(timer_id_i) < 32'(NUM_SLOTS));

  assign fire_now = ch_valid[NUM_SLOTS] && (ch_deadline[NUM_SLOTS] <= now_q);

  always_comb begin
    wr          = '0;
    wr_id       = IDW'(timer_id_i);
    wr_deadline = sat_add(now_c, duration_i);
    wr_mode     = dtq_pkg::ModeW'(kind_i);
    if (accept) begin
      case (kind_i)
        dtq_pkg::KindStartOneshot,
        dtq_pkg::KindStartTimeout,
        dtq_pkg::KindStartPeriodic: wr.load_all   = id_ok;
        dtq_pkg::KindStop:          wr.deactivate = id_ok;
        dtq_pkg::KindClear:         wr.clear_all  = 1'b1;
        default:                    wr            = '0;
      endcase
    end else if (state_q == dtq_pkg::StFire) begin
      wr_id       = ch_id[NUM_SLOTS];
      wr_deadline = sat_add(ch_deadline[NUM_SLOTS], ch_period[NUM_SLOTS]);
      if (ch_mode[NUM_SLOTS] == dtq_pkg::ModePeriodic) begin
        wr.load_deadline = fire_now;
      end else begin
        wr.deactivate = fire_now;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    poll_d       = poll_q;
    scanned_d    = scanned_q;
    fired_d      = fired_q;
    fired_id_d   = fired_id_q;
    fired_mode_d = fired_mode_q;
    out_load     = 1'b0;
    case (state_q)
      dtq_pkg::StIdle: begin
        if (accept) begin
          state_d      = dtq_pkg::StScan;
          cnt_d        = '0;
          poll_d       = (kind_i == dtq_pkg::KindPoll);
          scanned_d    = 1'b0;
          fired_d      = 1'b0;
          fired_id_d   = '0;
          fired_mode_d = '0;
        end
      end
      dtq_pkg::StScan: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          cnt_d   = '0;
          state_d = (poll_q && !scanned_q) ? dtq_pkg::StFire : dtq_pkg::StDone;
        end
      end
      dtq_pkg::StFire: begin
        scanned_d = 1'b1;
        state_d   = dtq_pkg::StScan;
        if (fire_now) begin
          fired_d      = 1'b1;
          fired_id_d   = ch_id[NUM_SLOTS];
          fired_mode_d = ch_mode[NUM_SLOTS];
        end
      end
      dtq_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = dtq_pkg::StIdle;
        end
      end
      default: state_d = dtq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dtq_pkg::StIdle;
      cnt_q        <= '0;
      poll_q       <= 1'b0;
      scanned_q    <= 1'b0;
      fired_q      <= 1'b0;
      fired_id_q   <= '0;
      fired_mode_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      poll_q       <= poll_d;
      scanned_q    <= scanned_d;
      fired_q      <= fired_d;
      fired_id_q   <= fired_id_d;
      fired_mode_q <= fired_mode_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign nd_w = NW'(ch_deadline[NUM_SLOTS]);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_c;
    end
    if (out_load) begin
      o_fired_q      <= fired_q;
      o_fired_id_q   <= dtq_pkg::IdPortW'(fired_id_q);
      o_fired_mode_q <= fired_mode_q;
      o_nd_q         <= ch_valid[NUM_SLOTS] ? nd_w[dtq_pkg::NdW-1:0] : '1;
      o_empty_q      <= !ch_valid[NUM_SLOTS];
    end
  end

  assign ch_valid[0]    = 1'b0;
  assign ch_deadline[0] = '0;
  assign ch_period[0]   = '0;
  assign ch_mode[0]     = '0;
  assign ch_id[0]       = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    dtq_cell #(
      .CELL_ID  (i),
      .IDW      (IDW),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wr_i          (wr),
      .wr_id_i       (wr_id),
      .wr_deadline_i (wr_deadline),
      .wr_period_i   (duration_i),
      .wr_mode_i     (wr_mode),
      .in_valid_i    (ch_valid[i]),
      .in_deadline_i (ch_deadline[i]),
      .in_period_i   (ch_period[i]),
      .in_mode_i     (ch_mode[i]),
      .in_id_i       (ch_id[i]),
      .out_valid_o   (ch_valid[i+1]),
      .out_deadline_o(ch_deadline[i+1]),
      .out_period_o  (ch_period[i+1]),
      .out_mode_o    (ch_mode[i+1]),
      .out_id_o      (ch_id[i+1])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign fired_o         = o_fired_q;
  assign fired_id_o      = o_fired_id_q;
  assign fired_mode_o    = o_fired_mode_q;
  assign next_deadline_o = o_nd_q;
  assign queue_empty_o   = o_empty_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("command accepted while previous one in flight");

  a_empty_nd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && queue_empty_o) |-> (next_deadline_o == '1))
    else $error("empty queue without all-ones next deadline");

  a_no_fire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fired_o) |-> (fired_id_o == '0 && fired_mode_o == '0))
    else $error("fire fields set without a fire");

  a_fire_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_o) |-> (fired_mode_o != 2'd3))
    else $error("fired slot with illegal mode");

endmodule
